### rtl/core/zwc_pkg.sv
// zwc_pkg: shared types, codes and helpers of the zlib wrapper checker
// no dependencies; used by every core module
`default_nettype none

package zwc_pkg;

  localparam logic [16:0] ADLER_MOD = 17'd65521;

  localparam logic [1:0] OP_CONTAINER = 2'd0;
  localparam logic [1:0] OP_OUTPUT    = 2'd1;
  localparam logic [1:0] OP_END       = 2'd2;

  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_HCHECK   = 3'd1;
  localparam logic [2:0] ERR_METHOD   = 3'd2;
  localparam logic [2:0] ERR_WINDOW   = 3'd3;
  localparam logic [2:0] ERR_DICT     = 3'd4;
  localparam logic [2:0] ERR_TRAILER  = 3'd5;
  localparam logic [2:0] ERR_TRAILING = 3'd6;
  localparam logic [2:0] ERR_DEFLATE  = 3'd7;

  localparam logic [3:0] METHOD_DEFLATE = 4'd8;

  typedef enum logic [2:0] {
    CMD_CONTAINER,
    CMD_DATA,
    CMD_END_OK,
    CMD_END_FAIL,
    CMD_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data_byte;
    logic        last_byte;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_port_t;

  // 2^5 = 1 mod 31, so folding 5-bit digits keeps the residue
  function automatic logic mod31_zero(input logic [15:0] v);
    logic [6:0] s1;
    logic [5:0] s2;
    s1 = {2'b00, v[4:0]} + {2'b00, v[9:5]} + {2'b00, v[14:10]} + {6'd0, v[15]};
    s2 = {1'b0, s1[4:0]} + {4'd0, s1[6:5]};
    return (s2 == 6'd0) || (s2 == 6'd31);
  endfunction

endpackage

`default_nettype wire

### rtl/core/zwc_item_if.sv
// zwc_item_if: input channel of the checker, valid/ready plus item fields
// no dependencies
`default_nettype none

interface zwc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       deflate_failed;

  modport source (output valid, operation, data_byte, last_byte, deflate_failed,
                  input ready);
  modport sink (input valid, operation, data_byte, last_byte, deflate_failed,
                output ready);
endinterface

`default_nettype wire

### rtl/core/zwc_result_if.sv
// zwc_result_if: result channel of the checker, valid/ready plus result fields
// no dependencies
`default_nettype none

interface zwc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  error_code;
  logic        in_compressed;
  logic [1:0]  comp_level;
  logic [3:0]  window_log;
  logic [31:0] running_checksum;

  modport source (output valid, status, error_code, in_compressed,
                  comp_level, window_log, running_checksum,
                  input ready);
  modport sink (input valid, status, error_code, in_compressed,
                comp_level, window_log, running_checksum,
                output ready);
endinterface

`default_nettype wire

### rtl/core/zwc_front.sv
// zwc_front: accepts input transactions and classifies them into commands
// depends on zwc_pkg and zwc_item_if
`default_nettype none

module zwc_front (
  zwc_item_if.sink   items,
  input  logic       q_full,
  output zwc_pkg::q_port_t push
);

  zwc_pkg::cmd_kind_t kind;

  always_comb begin
    case (items.operation)
      zwc_pkg::OP_CONTAINER: kind = zwc_pkg::CMD_CONTAINER;
      zwc_pkg::OP_OUTPUT:    kind = zwc_pkg::CMD_DATA;
      zwc_pkg::OP_END:       kind = items.deflate_failed ? zwc_pkg::CMD_END_FAIL
                                                         : zwc_pkg::CMD_END_OK;
      default:               kind = zwc_pkg::CMD_NONE;
    endcase
  end

  assign items.ready         = !q_full;
  assign push.valid          = items.valid && !q_full;
  assign push.cmd.kind       = kind;
  assign push.cmd.data_byte  = items.data_byte;
  assign push.cmd.last_byte  = items.last_byte;

endmodule

`default_nettype wire

### rtl/core/zwc_queue.sv
// zwc_queue: two-entry command queue between front and back
// depends on zwc_pkg
`default_nettype none

module zwc_queue (
  input  logic             clk,
  input  logic             rst,
  input  zwc_pkg::q_port_t push,
  input  logic             pop,
  output logic             full,
  output zwc_pkg::q_port_t head
);

  zwc_pkg::cmd_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push.valid} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_ptr] <= push.cmd;
  end

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.cmd   = mem[rd_ptr];

endmodule

`default_nettype wire

### rtl/core/zwc_back.sv
// zwc_back: container phase machine, adler-32 and the result register
// depends on zwc_pkg and zwc_result_if
`default_nettype none

module zwc_back (
  input  logic             clk,
  input  logic             rst,
  input  zwc_pkg::q_port_t head,
  output logic             pop,
  zwc_result_if.source     results
);

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_DICTID, PH_DICT, PH_DATA, PH_TRAIL, PH_DONE, PH_ERR
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  first_header_byte, first_header_byte_next;
  logic [1:0]  byte_counter, byte_counter_next;
  logic [31:0] dictionary_id, dictionary_id_next;
  logic [15:0] sum_low, sum_low_next;
  logic [15:0] sum_high, sum_high_next;
  logic [31:0] trailer_shift, trailer_shift_next;
  logic [3:0]  window_code, window_code_next;
  logic [1:0]  level_code, level_code_next;
  logic [2:0]  error_latch, error_latch_next;

  logic [16:0] lo_add, hi_add;
  logic [15:0] lo_new, hi_new;
  logic [7:0]  b;
  logic        last;

  assign b    = head.cmd.data_byte;
  assign last = head.cmd.last_byte;
  assign pop  = head.valid && (!results.valid || results.ready);

  // adler-32 step, each sum stays below twice the modulus
  always_comb begin
    lo_add = {1'b0, sum_low} + {9'd0, b};
    lo_new = (lo_add >= zwc_pkg::ADLER_MOD) ? 16'(lo_add - zwc_pkg::ADLER_MOD)
                                            : lo_add[15:0];
    hi_add = {1'b0, sum_high} + {1'b0, lo_new};
    hi_new = (hi_add >= zwc_pkg::ADLER_MOD) ? 16'(hi_add - zwc_pkg::ADLER_MOD)
                                            : hi_add[15:0];
  end

  always_comb begin
    phase_next             = phase;
    first_header_byte_next = first_header_byte;
    byte_counter_next      = byte_counter;
    dictionary_id_next     = dictionary_id;
    sum_low_next           = sum_low;
    sum_high_next          = sum_high;
    trailer_shift_next     = trailer_shift;
    window_code_next       = window_code;
    level_code_next        = level_code;
    error_latch_next       = error_latch;
    if (pop && phase != PH_ERR) begin
      case (head.cmd.kind)
        zwc_pkg::CMD_CONTAINER: begin
          case (phase)
            PH_HDR0: begin
              first_header_byte_next = b;
              phase_next = PH_HDR1;
              if (last) begin
                phase_next = PH_ERR;
                error_latch_next = zwc_pkg::ERR_TRAILING;
              end
            end
            PH_HDR1: begin
              if (!zwc_pkg::mod31_zero({first_header_byte, b})) begin
                phase_next = PH_ERR;
                error_latch_next = zwc_pkg::ERR_HCHECK;
              end else if (first_header_byte[3:0] != zwc_pkg::METHOD_DEFLATE) begin
                phase_next = PH_ERR;
                error_latch_next = zwc_pkg::ERR_METHOD;
              end else if (first_header_byte[7]) begin
                phase_next = PH_ERR;
                error_latch_next = zwc_pkg::ERR_WINDOW;
              end else begin
                window_code_next  = first_header_byte[7:4];
                level_code_next   = b[7:6];
                sum_low_next      = 16'd1;
                sum_high_next     = 16'd0;
                byte_counter_next = 2'd0;
                if (b[5]) begin
                  phase_next = PH_DICTID;
                  dictionary_id_next = 32'd0;
                end else begin
                  phase_next = PH_DATA;
                end
                if (last) begin
                  phase_next = PH_ERR;
                  error_latch_next = zwc_pkg::ERR_TRAILING;
                end
              end
            end
            PH_DICTID: begin
              dictionary_id_next = {dictionary_id[23:0], b};
              if (byte_counter == 2'd3) begin
                byte_counter_next = 2'd0;
                phase_next = ({dictionary_id[23:0], b} == {sum_high, sum_low})
                             ? PH_DATA : PH_DICT;
              end else begin
                byte_counter_next = byte_counter + 2'd1;
              end
              if (last) begin
                phase_next = PH_ERR;
                error_latch_next = zwc_pkg::ERR_TRAILING;
              end
            end
            PH_DICT: begin
              sum_low_next  = lo_new;
              sum_high_next = hi_new;
              if ({hi_new, lo_new} == dictionary_id) begin
                sum_low_next  = 16'd1;
                sum_high_next = 16'd0;
                phase_next    = PH_DATA;
                if (last) begin
                  phase_next = PH_ERR;
                  error_latch_next = zwc_pkg::ERR_TRAILING;
                end
              end else if (last) begin
                phase_next = PH_ERR;
                error_latch_next = zwc_pkg::ERR_DICT;
              end
            end
            PH_DATA: begin
              if (last) begin
                phase_next = PH_ERR;
                error_latch_next = zwc_pkg::ERR_TRAILING;
              end
            end
            PH_TRAIL: begin
              trailer_shift_next = {trailer_shift[23:0], b};
              if (byte_counter == 2'd3) begin
                byte_counter_next = 2'd0;
                if ({trailer_shift[23:0], b} != {sum_high, sum_low}) begin
                  phase_next = PH_ERR;
                  error_latch_next = zwc_pkg::ERR_TRAILER;
                end else if (last) begin
                  phase_next = PH_DONE;
                end else begin
                  phase_next = PH_ERR;
                  error_latch_next = zwc_pkg::ERR_TRAILING;
                end
              end else begin
                byte_counter_next = byte_counter + 2'd1;
                if (last) begin
                  phase_next = PH_ERR;
                  error_latch_next = zwc_pkg::ERR_TRAILING;
                end
              end
            end
            PH_DONE: begin
              phase_next = PH_ERR;
              error_latch_next = zwc_pkg::ERR_TRAILING;
            end
            default: ;
          endcase
        end
        zwc_pkg::CMD_DATA: begin
          if (phase == PH_DATA) begin
            sum_low_next  = lo_new;
            sum_high_next = hi_new;
          end
        end
        zwc_pkg::CMD_END_OK: begin
          if (phase == PH_DATA) begin
            phase_next         = PH_TRAIL;
            byte_counter_next  = 2'd0;
            trailer_shift_next = 32'd0;
          end
        end
        zwc_pkg::CMD_END_FAIL: begin
          if (phase == PH_DATA) begin
            phase_next = PH_ERR;
            error_latch_next = zwc_pkg::ERR_DEFLATE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR0;
      first_header_byte <= 8'd0;
      byte_counter      <= 2'd0;
      dictionary_id     <= 32'd0;
      sum_low           <= 16'd1;
      sum_high          <= 16'd0;
      trailer_shift     <= 32'd0;
      window_code       <= 4'd0;
      level_code        <= 2'd0;
      error_latch       <= zwc_pkg::ERR_NONE;
      results.valid     <= 1'b0;
    end else begin
      phase             <= phase_next;
      first_header_byte <= first_header_byte_next;
      byte_counter      <= byte_counter_next;
      dictionary_id     <= dictionary_id_next;
      sum_low           <= sum_low_next;
      sum_high          <= sum_high_next;
      trailer_shift     <= trailer_shift_next;
      window_code       <= window_code_next;
      level_code        <= level_code_next;
      error_latch       <= error_latch_next;
      if (pop) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
    if (pop) begin
      results.status <= (phase_next == PH_ERR) ? zwc_pkg::ST_ERROR :
                        (phase_next == PH_DONE) ? zwc_pkg::ST_DONE : zwc_pkg::ST_BUSY;
      results.error_code        <= error_latch_next;
      results.in_compressed     <= (phase_next == PH_DATA);
      results.comp_level        <= level_code_next;
      results.window_log        <= window_code_next + 4'd8;
      results.running_checksum  <= {sum_high_next, sum_low_next};
    end
  end

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERR |=> phase == PH_ERR)
    else $error("error phase left");
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERR) == (error_latch != zwc_pkg::ERR_NONE))
    else $error("error code and phase disagree");
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    sum_low < zwc_pkg::ADLER_MOD[15:0] && sum_high < zwc_pkg::ADLER_MOD[15:0])
    else $error("adler sum out of range");
  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !pop |=> phase == $past(phase) && sum_low == $past(sum_low))
    else $error("state moved without a transaction");
`endif

endmodule

`default_nettype wire

### rtl/core/zlib_wrapper_checker.sv
// zlib_wrapper_checker: top level, front classifier, command queue and back end
// a transaction is queued, then popped by the back end, which registers its result
// throughput: one transaction per cycle while results are taken, set by the combinational adler-32 step in the back end
// the two-entry queue and the result register let either side stall on its own
// reset: synchronous active-high rst empties the queue and result register and
// returns the checker to the first header byte with the checksum at one
`default_nettype none

module zlib_wrapper_checker (
  input  logic         clk,
  input  logic         rst,
  zwc_item_if.sink     items,
  zwc_result_if.source results
);

  zwc_pkg::q_port_t push;
  zwc_pkg::q_port_t head;
  logic             q_full;
  logic             pop;

  zwc_front u_front (
    .items  (items),
    .q_full (q_full),
    .push   (push)
  );

  zwc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  zwc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule

`default_nettype wire

### dv/zlib_wrapper_checker_test.sv
`timescale 1ns / 100ps
// zlib_wrapper_checker_test: self-checking bench for the zlib container checker
// drives one noisy stream with a clean or faulty end through the item channel, scores every result
// depends on zwc_pkg, zwc_item_if, zwc_result_if and zlib_wrapper_checker

module zlib_wrapper_checker_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DIRECTED_ROWS = 20;
  localparam int RANDOM_ITEMS = 1880;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef enum logic [2:0] {
    S_HDR_CMF, S_HDR_FLG, S_DICT_ID, S_DICT, S_DEFLATE, S_TRAILER, S_DONE, S_ERROR
  } stage_t;

  typedef enum int {
    FIN_CLEAN, FIN_BAD_SUM, FIN_NO_LAST, FIN_CUT_TRAILER, FIN_CUT_DATA, FIN_DEFLATE_FAIL
  } finale_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       last;
    logic       dfail;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  error_code;
    logic        in_compressed;
    logic [1:0]  comp_level;
    logic [3:0]  window_log;
    logic [31:0] running_checksum;
  } verdict_t;

  typedef struct packed {
    item_t    it;
    logic     typed;
    verdict_t want;
  } row_t;

  localparam verdict_t RESET_VIEW =
    '{zwc_pkg::ST_BUSY, zwc_pkg::ERR_NONE, 1'b0, 2'd0, 4'd8, 32'd1};
  localparam verdict_t HDR_VIEW =
    '{zwc_pkg::ST_BUSY, zwc_pkg::ERR_NONE, 1'b0, 2'd3, 4'd15, 32'd1};
  localparam verdict_t DICT_VIEW =
    '{zwc_pkg::ST_BUSY, zwc_pkg::ERR_NONE, 1'b1, 2'd3, 4'd15, 32'd1};
  localparam verdict_t NO_VIEW    = '0;

  logic clk;
  logic rst;
  logic calm;
  int   mismatches;

  zwc_item_if   item_bus ();
  zwc_result_if result_bus ();

  zlib_wrapper_checker dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_bus),
    .results (result_bus)
  );

  // predictor state
  stage_t      stage;
  logic [7:0]  cmf_byte;
  logic [1:0]  octet_idx;
  logic [31:0] dict_word;
  logic [31:0] adler;
  logic [31:0] trailer_word;
  logic [3:0]  win_field;
  logic [1:0]  level_field;
  logic [2:0]  err_seen;

  verdict_t pending_verdicts [$];
  row_t     directed_rows [DIRECTED_ROWS];

  function automatic logic [31:0] adler_update(input logic [31:0] s, input logic [7:0] b);
    logic [16:0] lo;
    logic [16:0] hi;
    lo = {1'b0, s[15:0]} + {9'd0, b};
    if (lo >= zwc_pkg::ADLER_MOD) lo = lo - zwc_pkg::ADLER_MOD;
    hi = {1'b0, s[31:16]} + lo;
    if (hi >= zwc_pkg::ADLER_MOD) hi = hi - zwc_pkg::ADLER_MOD;
    return {hi[15:0], lo[15:0]};
  endfunction

  function automatic void flag_error(input logic [2:0] code);
    stage = S_ERROR;
    err_seen = code;
  endfunction

  function automatic verdict_t expected_verdict(input item_t it);
    logic [15:0] hdr;
    verdict_t    v;
    if (stage != S_ERROR) begin
      case (it.op)
        zwc_pkg::OP_CONTAINER: begin
          case (stage)
            S_HDR_CMF: begin
              cmf_byte = it.data;
              stage = S_HDR_FLG;
              if (it.last) flag_error(zwc_pkg::ERR_TRAILING);
            end
            S_HDR_FLG: begin
              hdr = {cmf_byte, it.data};
              if ((hdr % 16'd31) != 16'd0) flag_error(zwc_pkg::ERR_HCHECK);
              else if (cmf_byte[3:0] != zwc_pkg::METHOD_DEFLATE)
                flag_error(zwc_pkg::ERR_METHOD);
              else if (cmf_byte[7:4] > 4'd7) flag_error(zwc_pkg::ERR_WINDOW);
              else begin
                win_field = cmf_byte[7:4];
                level_field = it.data[7:6];
                adler = 32'd1;
                octet_idx = 2'd0;
                if (it.data[5]) begin
                  stage = S_DICT_ID;
                  dict_word = 32'd0;
                end else begin
                  stage = S_DEFLATE;
                end
                if (it.last) flag_error(zwc_pkg::ERR_TRAILING);
              end
            end
            S_DICT_ID: begin
              dict_word = {dict_word[23:0], it.data};
              if (octet_idx == 2'd3) begin
                octet_idx = 2'd0;
                stage = (dict_word == adler) ? S_DEFLATE : S_DICT;
              end else begin
                octet_idx = octet_idx + 2'd1;
              end
              if (it.last) flag_error(zwc_pkg::ERR_TRAILING);
            end
            S_DICT: begin
              adler = adler_update(adler, it.data);
              if (adler == dict_word) begin
                adler = 32'd1;
                stage = S_DEFLATE;
                if (it.last) flag_error(zwc_pkg::ERR_TRAILING);
              end else if (it.last) begin
                flag_error(zwc_pkg::ERR_DICT);
              end
            end
            S_DEFLATE: begin
              if (it.last) flag_error(zwc_pkg::ERR_TRAILING);
            end
            S_TRAILER: begin
              trailer_word = {trailer_word[23:0], it.data};
              if (octet_idx == 2'd3) begin
                octet_idx = 2'd0;
                if (trailer_word != adler) flag_error(zwc_pkg::ERR_TRAILER);
                else if (it.last) stage = S_DONE;
                else flag_error(zwc_pkg::ERR_TRAILING);
              end else begin
                octet_idx = octet_idx + 2'd1;
                if (it.last) flag_error(zwc_pkg::ERR_TRAILING);
              end
            end
            S_DONE: flag_error(zwc_pkg::ERR_TRAILING);
            default: ;
          endcase
        end
        zwc_pkg::OP_OUTPUT: begin
          if (stage == S_DEFLATE) adler = adler_update(adler, it.data);
        end
        zwc_pkg::OP_END: begin
          if (stage == S_DEFLATE) begin
            if (it.dfail) begin
              flag_error(zwc_pkg::ERR_DEFLATE);
            end else begin
              stage = S_TRAILER;
              octet_idx = 2'd0;
              trailer_word = 32'd0;
            end
          end
        end
        default: ;
      endcase
    end
    v.status = (stage == S_ERROR) ? zwc_pkg::ST_ERROR :
               ((stage == S_DONE) ? zwc_pkg::ST_DONE : zwc_pkg::ST_BUSY);
    v.error_code = err_seen;
    v.in_compressed = (stage == S_DEFLATE);
    v.comp_level = level_field;
    v.window_log = win_field + 4'd8;
    v.running_checksum = adler;
    return v;
  endfunction

  task automatic send_item(input item_t it, input logic typed, input verdict_t want);
    verdict_t v;
    while (!calm && $urandom_range(99) < 23) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid          <= 1'b1;
    item_bus.operation      <= it.op;
    item_bus.data_byte      <= it.data;
    item_bus.last_byte      <= it.last;
    item_bus.deflate_failed <= it.dfail;
    do @(posedge clk); while (!item_bus.ready);
    v = expected_verdict(it);
    pending_verdicts.push_back(typed ? want : v);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    result_bus.ready <= calm || ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin : result_monitor
    verdict_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got checksum %h",
                 $time, result_bus.running_checksum);
      end else begin
        want = pending_verdicts.pop_front();
        check_field("status", 32'(want.status), 32'(result_bus.status));
        check_field("error_code", 32'(want.error_code), 32'(result_bus.error_code));
        check_field("in_compressed", 32'(want.in_compressed),
                    32'(result_bus.in_compressed));
        check_field("comp_level", 32'(want.comp_level), 32'(result_bus.comp_level));
        check_field("window_log", 32'(want.window_log), 32'(result_bus.window_log));
        check_field("running_checksum", want.running_checksum,
                    result_bus.running_checksum);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    do begin
      @(posedge clk);
      if (rst || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
        quiet = 0;
      else
        quiet++;
    end while (quiet < STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    item_t       it;
    int          r;
    int          pick;
    int          cut;
    finale_t     finale;
    logic [31:0] word;

    item_bus.valid          <= 1'b0;
    item_bus.operation      <= zwc_pkg::OP_CONTAINER;
    item_bus.data_byte      <= 8'd0;
    item_bus.last_byte      <= 1'b0;
    item_bus.deflate_failed <= 1'b0;
    rst <= 1'b1;
    calm = 1'b0;
    mismatches = 0;

    stage = S_HDR_CMF;
    cmf_byte = 8'd0;
    octet_idx = 2'd0;
    dict_word = 32'd0;
    adler = 32'd1;
    trailer_word = 32'd0;
    win_field = 4'd0;
    level_field = 2'd0;
    err_seen = zwc_pkg::ERR_NONE;

    // header 78 f9 asks for dictionary id 012600c4, the checksum of "ab"
    directed_rows = '{
      '{'{zwc_pkg::OP_OUTPUT,    8'hff, 1'b0, 1'b0}, 1'b1, RESET_VIEW},
      '{'{zwc_pkg::OP_END,       8'h00, 1'b0, 1'b1}, 1'b1, RESET_VIEW},
      '{'{OP_UNUSED,             8'haa, 1'b1, 1'b1}, 1'b1, RESET_VIEW},
      '{'{zwc_pkg::OP_CONTAINER, 8'h78, 1'b0, 1'b0}, 1'b1, RESET_VIEW},
      '{'{zwc_pkg::OP_CONTAINER, 8'hf9, 1'b0, 1'b0}, 1'b1, HDR_VIEW},
      '{'{zwc_pkg::OP_CONTAINER, 8'h01, 1'b0, 1'b0}, 1'b0, NO_VIEW},
      '{'{zwc_pkg::OP_OUTPUT,    8'h00, 1'b0, 1'b0}, 1'b0, NO_VIEW},
      '{'{zwc_pkg::OP_CONTAINER, 8'h26, 1'b0, 1'b0}, 1'b0, NO_VIEW},
      '{'{zwc_pkg::OP_CONTAINER, 8'h00, 1'b0, 1'b0}, 1'b0, NO_VIEW},
      '{'{zwc_pkg::OP_END,       8'h00, 1'b0, 1'b0}, 1'b0, NO_VIEW},
      '{'{zwc_pkg::OP_CONTAINER, 8'hc4, 1'b0, 1'b0}, 1'b0, NO_VIEW},
      '{'{zwc_pkg::OP_CONTAINER, 8'h61, 1'b0, 1'b0}, 1'b0, NO_VIEW},
      '{'{zwc_pkg::OP_OUTPUT,    8'h55, 1'b0, 1'b0}, 1'b0, NO_VIEW},
      '{'{zwc_pkg::OP_CONTAINER, 8'h62, 1'b0, 1'b0}, 1'b1, DICT_VIEW},
      '{'{zwc_pkg::OP_OUTPUT,    8'h00, 1'b0, 1'b0}, 1'b0, NO_VIEW},
      '{'{zwc_pkg::OP_OUTPUT,    8'hff, 1'b0, 1'b0}, 1'b0, NO_VIEW},
      '{'{zwc_pkg::OP_CONTAINER, 8'h00, 1'b0, 1'b0}, 1'b0, NO_VIEW},
      '{'{zwc_pkg::OP_CONTAINER, 8'hff, 1'b0, 1'b0}, 1'b0, NO_VIEW},
      '{'{OP_UNUSED,             8'hff, 1'b1, 1'b1}, 1'b0, NO_VIEW},
      '{'{zwc_pkg::OP_OUTPUT,    8'hff, 1'b0, 1'b1}, 1'b0, NO_VIEW}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_item(directed_rows[i].it, directed_rows[i].typed,
                                         directed_rows[i].want);

    // deflate data phase: decompressed bytes, raw deflate bytes and stray codes
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      calm = (k >= 600 && k < 900);
      if (k == 1200) begin
        item_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_verdicts.size() != 0);
      end
      r = $urandom_range(19);
      it.data  = (r == 0) ? 8'h00 : ((r == 1) ? 8'hff : 8'($urandom));
      it.last  = 1'($urandom_range(1));
      it.dfail = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (r < 72) begin
        it.op = zwc_pkg::OP_OUTPUT;
      end else if (r < 90) begin
        it.op = zwc_pkg::OP_CONTAINER;
        it.last = 1'b0;
      end else begin
        it.op = OP_UNUSED;
      end
      send_item(it, 1'b0, NO_VIEW);
    end
    calm = 1'b0;

    pick = $urandom_range(9);
    finale = (pick < 5) ? FIN_CLEAN : finale_t'(pick - 4);
    it.dfail = 1'b0;
    it.last = 1'b0;
    if (finale == FIN_DEFLATE_FAIL) begin
      it.op = zwc_pkg::OP_END;
      it.dfail = 1'b1;
      send_item(it, 1'b0, NO_VIEW);
    end else if (finale == FIN_CUT_DATA) begin
      it.op = zwc_pkg::OP_CONTAINER;
      it.data = 8'($urandom);
      it.last = 1'b1;
      send_item(it, 1'b0, NO_VIEW);
    end else begin
      it.op = zwc_pkg::OP_END;
      send_item(it, 1'b0, NO_VIEW);
      word = adler;
      if (finale == FIN_BAD_SUM) word = word ^ (32'd1 << $urandom_range(31));
      cut = (finale == FIN_CUT_TRAILER) ? $urandom_range(2) : 3;
      for (int i = 0; i <= cut; i++) begin
        if ($urandom_range(2) == 0) begin
          it.op = $urandom_range(1) ? zwc_pkg::OP_OUTPUT : zwc_pkg::OP_END;
          it.data = 8'($urandom);
          it.last = 1'($urandom_range(1));
          it.dfail = 1'($urandom_range(1));
          send_item(it, 1'b0, NO_VIEW);
        end
        it.op = zwc_pkg::OP_CONTAINER;
        it.data = word[31 - 8*i -: 8];
        it.dfail = 1'b0;
        it.last = 1'b0;
        if (i == cut) begin
          if (finale == FIN_BAD_SUM) it.last = 1'($urandom_range(1));
          else if (finale != FIN_NO_LAST) it.last = 1'b1;
        end
        send_item(it, 1'b0, NO_VIEW);
      end
      if (finale == FIN_CLEAN) begin
        // stray items after a finished stream, then a trailing byte
        it.op = zwc_pkg::OP_OUTPUT;
        it.data = 8'($urandom);
        send_item(it, 1'b0, NO_VIEW);
        it.op = zwc_pkg::OP_END;
        it.dfail = 1'($urandom_range(1));
        send_item(it, 1'b0, NO_VIEW);
        it.op = zwc_pkg::OP_CONTAINER;
        it.last = 1'($urandom_range(1));
        send_item(it, 1'b0, NO_VIEW);
      end
    end

    // everything after the latched error is ignored
    repeat (20) begin
      it.op = 2'($urandom_range(3));
      it.data = 8'($urandom);
      it.last = 1'($urandom_range(1));
      it.dfail = 1'($urandom_range(1));
      send_item(it, 1'b0, NO_VIEW);
    end
    item_bus.valid <= 1'b0;

    do @(posedge clk); while (pending_verdicts.size() != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
rtl/core/zwc_pkg.sv
rtl/core/zwc_item_if.sv
rtl/core/zwc_result_if.sv
rtl/core/zwc_front.sv
rtl/core/zwc_queue.sv
rtl/core/zwc_back.sv
rtl/core/zlib_wrapper_checker.sv
dv/zlib_wrapper_checker_test.sv
